>>> src/assert_macros.svh
// Shared assertion macros for the connectivity generator checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define SGC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sgc check failed");

// Next-cycle implication, quiet while reset is asserted.
`define SGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sgc check failed");

`endif

>>> src/sgc_pkg.sv
package sgc_pkg;

	// Request kinds.
	localparam logic [1:0] OP_FACE_A = 2'd0;
	localparam logic [1:0] OP_FACE_B = 2'd1;
	localparam logic [1:0] OP_FACE_C = 2'd2;
	localparam logic [1:0] OP_CELL   = 2'd3;

	// Grid dimension codes.
	localparam logic [1:0] DIM_1 = 2'd1;
	localparam logic [1:0] DIM_2 = 2'd2;
	localparam logic [1:0] DIM_3 = 2'd3;

	// Register indexes.
	localparam logic [1:0] REG_SIZE_I    = 2'd0;
	localparam logic [1:0] REG_SIZE_J    = 2'd1;
	localparam logic [1:0] REG_SIZE_K    = 2'd2;
	localparam logic [1:0] REG_UNCOUNTED = 2'd3;

	// Largest legal number of points on one axis.
	localparam int MAX_AXIS = 1024;

	localparam int ADDR_W = 34;
	localparam int VAL_W  = 32;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [VAL_W-1:0]  val_t;

	// One row ready for serialisation.
	typedef struct packed {
		logic       err;
		logic       arr;
		logic       hdr;
		logic [2:0] cnt;
		addr_t      base;
		val_t [5:0] vals;
	} row_t;

endpackage

>>> src/sgc_if.sv
interface sgc_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [9:0] coord_a;
	logic [9:0] coord_b;
	logic [9:0] coord_c;

	modport source (output valid, operation, coord_a, coord_b, coord_c, input ready);
	modport sink (input valid, operation, coord_a, coord_b, coord_c, output ready);
endinterface

interface sgc_word_if;
	logic                       valid;
	logic                       ready;
	logic                       target_array;
	logic [sgc_pkg::ADDR_W-1:0] address;
	logic [sgc_pkg::VAL_W-1:0]  value;
	logic                       is_count;
	logic                       last;
	logic                       error;

	modport source (output valid, target_array, address, value, is_count, last, error,
		input ready);
	modport sink (input valid, target_array, address, value, is_count, last, error,
		output ready);
endinterface

>>> src/sgc_emit.sv
module sgc_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_valid,
	output logic              load_ready,
	input  sgc_pkg::row_t     load_row,
	sgc_word_if.source        rsp
);
	sgc_pkg::row_t row_q;
	logic          valid_q;
	logic [2:0]    idx_q;
	logic [2:0]    nwords;
	logic [2:0]    k;
	logic          last;
	sgc_pkg::val_t sel;

	assign nwords = row_q.err ? 3'd1 : row_q.cnt + {2'd0, row_q.hdr};
	assign last   = (idx_q == nwords - 3'd1);
	assign k      = idx_q - {2'd0, row_q.hdr};

	always_comb begin
		case (k)
			3'd0: sel = row_q.vals[0];
			3'd1: sel = row_q.vals[1];
			3'd2: sel = row_q.vals[2];
			3'd3: sel = row_q.vals[3];
			3'd4: sel = row_q.vals[4];
			3'd5: sel = row_q.vals[5];
			default: sel = '0;
		endcase
	end

	assign load_ready = !valid_q || (rsp.ready && last);

	assign rsp.valid        = valid_q;
	assign rsp.last         = last;
	assign rsp.error        = row_q.err;
	assign rsp.target_array = row_q.err ? 1'b0 : row_q.arr;
	assign rsp.is_count     = !row_q.err && row_q.hdr && (idx_q == 3'd0);
	assign rsp.address      = row_q.err ? '0 : row_q.base + sgc_pkg::addr_t'(idx_q);
	assign rsp.value        = row_q.err ? '0 :
		(row_q.hdr && idx_q == 3'd0) ? sgc_pkg::val_t'(row_q.cnt) : sel + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load_ready) begin
			valid_q <= load_valid;
			idx_q   <= '0;
		end else if (rsp.ready) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ready && load_valid) begin
			row_q <= load_row;
		end
	end
endmodule

>>> src/structured_grid_connectivity_gen.sv
// Structured grid to polyhedral connectivity index generator.
// Channels: req (sink) takes one request per transfer: operation and the
// coordinates on the active axes. rsp (source) gives one word per transfer:
// target_array, address, value, is_count, last and error. A request yields
// one to seven words; the final one carries last.
// Configuration: APB write to 4*i (size_i, size_j, size_k, uncounted_rows),
// pready always high, reads return the register. Write only while idle.
// Pipeline: a request enters a five-stage arithmetic pipeline (products of
// the axis sizes, products with the coordinates, partial sums, row words,
// row offset), and its row then passes to the word serialiser.
// Throughput: one word per cycle on rsp while rsp.ready is high; the single
// word serialiser at the end sends a request's words (up to seven) in turn.
// The pipeline takes a request every cycle until its last stage holds a row
// that the serialiser cannot take yet; then the whole pipeline holds.
// Reset: all valid bits clear, sizes return to 2 and rows carry counts.
// Stall: when rsp.ready is low the current word holds, the pipeline freezes
// as a whole once its last stage is full, and req.ready drops; nothing is
// lost or repeated.
module structured_grid_connectivity_gen (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	sgc_req_if.sink     req,
	sgc_word_if.source  rsp
);
	// ---------------- configuration ----------------
	logic [10:0] size_i_q, size_j_q, size_k_q;
	logic        uncounted_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_i_q    <= 11'd2;
			size_j_q    <= 11'd2;
			size_k_q    <= 11'd2;
			uncounted_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				sgc_pkg::REG_SIZE_I:    size_i_q    <= pwdata[10:0];
				sgc_pkg::REG_SIZE_J:    size_j_q    <= pwdata[10:0];
				sgc_pkg::REG_SIZE_K:    size_k_q    <= pwdata[10:0];
				sgc_pkg::REG_UNCOUNTED: uncounted_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			sgc_pkg::REG_SIZE_I:    prdata = {21'd0, size_i_q};
			sgc_pkg::REG_SIZE_J:    prdata = {21'd0, size_j_q};
			sgc_pkg::REG_SIZE_K:    prdata = {21'd0, size_k_q};
			sgc_pkg::REG_UNCOUNTED: prdata = {31'd0, uncounted_q};
			default:                prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	// Every stage advances together; hold all of them when the last is full
	// and the serialiser cannot take its row.
	logic adv;
	logic load_ready;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	assign adv       = !v_s5 || load_ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// ---------------- stage 1: active axes, range check, size products ----
	logic [1:0]  dim;
	logic [10:0] x, y, z, x1, y1, z1, n1;
	logic [10:0] ea, eb, ec;
	logic        size_err, err;

	always_comb begin
		dim = sgc_pkg::DIM_3;
		if (size_i_q == 11'd1)
			dim = (size_j_q == 11'd1 || size_k_q == 11'd1) ? sgc_pkg::DIM_1 : sgc_pkg::DIM_2;
		else if (size_j_q == 11'd1)
			dim = (size_k_q == 11'd1) ? sgc_pkg::DIM_1 : sgc_pkg::DIM_2;
		else if (size_k_q == 11'd1)
			dim = sgc_pkg::DIM_2;

		x = size_i_q;
		y = size_j_q;
		z = size_k_q;
		case (dim)
			sgc_pkg::DIM_1: begin
				if (size_j_q == 11'd1 && size_k_q == 11'd1) x = size_i_q;
				else if (size_i_q == 11'd1 && size_k_q == 11'd1) x = size_j_q;
				else x = size_k_q;
				y = 11'd1;
				z = 11'd1;
			end
			sgc_pkg::DIM_2: begin
				if (size_k_q == 11'd1) begin
					x = size_i_q;
					y = size_j_q;
				end else if (size_j_q == 11'd1) begin
					x = size_i_q;
					y = size_k_q;
				end else begin
					x = size_j_q;
					y = size_k_q;
				end
				z = 11'd1;
			end
			default: ;
		endcase
		x1 = x - 11'd1;
		y1 = y - 11'd1;
		z1 = z - 11'd1;
		n1 = (x > 11'd1) ? x1 : 11'd1;

		ea = {1'b0, req.coord_a};
		eb = {1'b0, req.coord_b};
		ec = {1'b0, req.coord_c};

		size_err = size_i_q == 11'd0 || size_j_q == 11'd0 || size_k_q == 11'd0 ||
			32'(size_i_q) > 32'(sgc_pkg::MAX_AXIS) ||
			32'(size_j_q) > 32'(sgc_pkg::MAX_AXIS) ||
			32'(size_k_q) > 32'(sgc_pkg::MAX_AXIS);

		err = 1'b1;
		case (dim)
			sgc_pkg::DIM_1: begin
				case (req.operation)
					sgc_pkg::OP_FACE_A: err = ea >= x;
					sgc_pkg::OP_CELL:   err = ea >= n1;
					default:            err = 1'b1;
				endcase
			end
			sgc_pkg::DIM_2: begin
				case (req.operation)
					sgc_pkg::OP_FACE_A: err = ea >= x || eb >= y1;
					sgc_pkg::OP_FACE_B: err = ea >= x1 || eb >= y;
					sgc_pkg::OP_CELL:   err = ea >= x1 || eb >= y1;
					default:            err = 1'b1;
				endcase
			end
			default: begin
				case (req.operation)
					sgc_pkg::OP_FACE_A: err = ea >= x || eb >= y1 || ec >= z1;
					sgc_pkg::OP_FACE_B: err = ea >= x1 || eb >= y || ec >= z1;
					sgc_pkg::OP_FACE_C: err = ea >= x1 || eb >= y1 || ec >= z;
					default:            err = ea >= x1 || eb >= y1 || ec >= z1;
				endcase
			end
		endcase
		err = err || size_err;
	end

	logic [1:0]  op_s1, dim_s1;
	logic        err_s1, hdr_s1;
	logic [9:0]  a_s1, c_s1;
	logic [10:0] x_s1, x1_s1, z1_s1;
	logic [21:0] xy_s1, xy1_s1, x1y_s1, x1y1_s1;
	logic [20:0] bx_s1, bx1_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= req.operation;
			dim_s1  <= dim;
			err_s1  <= err;
			hdr_s1  <= !uncounted_q;
			a_s1    <= req.coord_a;
			c_s1    <= req.coord_c;
			x_s1    <= x;
			x1_s1   <= x1;
			z1_s1   <= z1;
			xy_s1   <= 22'(x) * 22'(y);
			xy1_s1  <= 22'(x) * 22'(y1);
			x1y_s1  <= 22'(x1) * 22'(y);
			x1y1_s1 <= 22'(x1) * 22'(y1);
			bx_s1   <= 21'(req.coord_b) * 21'(x);
			bx1_s1  <= 21'(req.coord_b) * 21'(x1);
		end
	end

	// ---------------- stage 2: face counts, third-axis products -----------
	logic [1:0]  op_s2, dim_s2;
	logic        err_s2, hdr_s2;
	logic [9:0]  a_s2;
	logic [10:0] x_s2, x1_s2;
	logic [21:0] xy_s2, xy1_s2, x1y1_s2;
	logic [20:0] bx_s2, bx1_s2;
	logic [32:0] nfa_s2, nfb_s2;
	logic [31:0] cxy_s2, cxy1_s2, cx1y_s2, cx1y1_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2    <= op_s1;
			dim_s2   <= dim_s1;
			err_s2   <= err_s1;
			hdr_s2   <= hdr_s1;
			a_s2     <= a_s1;
			x_s2     <= x_s1;
			x1_s2    <= x1_s1;
			xy_s2    <= xy_s1;
			xy1_s2   <= xy1_s1;
			x1y1_s2  <= x1y1_s1;
			bx_s2    <= bx_s1;
			bx1_s2   <= bx1_s1;
			nfa_s2   <= 33'(xy1_s1) * 33'(z1_s1);
			nfb_s2   <= 33'(x1y_s1) * 33'(z1_s1);
			cxy_s2   <= 32'(c_s1) * 32'(xy_s1);
			cxy1_s2  <= 32'(c_s1) * 32'(xy1_s1);
			cx1y_s2  <= 32'(c_s1) * 32'(x1y_s1);
			cx1y1_s2 <= 32'(c_s1) * 32'(x1y1_s1);
		end
	end

	// ---------------- stage 3: partial sums -------------------------------
	logic [1:0]  op_s3, dim_s3;
	logic        err_s3, hdr_s3;
	logic [9:0]  a_s3;
	logic [10:0] x_s3, x1_s3;
	logic [21:0] xy_s3, xy1_s3, x1y1_s3;
	sgc_pkg::addr_t tp_s3, tr0_s3, tr1_s3, tr2_s3, q0_s3, q1_s3, nfa_s3, nfab_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s3   <= op_s2;
			dim_s3  <= dim_s2;
			err_s3  <= err_s2;
			hdr_s3  <= hdr_s2;
			a_s3    <= a_s2;
			x_s3    <= x_s2;
			x1_s3   <= x1_s2;
			xy_s3   <= xy_s2;
			xy1_s3  <= xy1_s2;
			x1y1_s3 <= x1y1_s2;
			q0_s3   <= 34'(a_s2) + 34'(bx_s2);
			q1_s3   <= 34'(a_s2) + 34'(bx1_s2);
			tp_s3   <= 34'(a_s2) + 34'(bx_s2) + 34'(cxy_s2);
			tr0_s3  <= 34'(a_s2) + 34'(bx_s2) + 34'(cxy1_s2);
			tr1_s3  <= 34'(a_s2) + 34'(bx1_s2) + 34'(cx1y_s2);
			tr2_s3  <= 34'(a_s2) + 34'(bx1_s2) + 34'(cx1y1_s2);
			nfa_s3  <= 34'(nfa_s2);
			nfab_s3 <= 34'(nfa_s2) + 34'(nfb_s2);
		end
	end

	// ---------------- stage 4: row number and node or face numbers --------
	sgc_pkg::addr_t row;
	sgc_pkg::addr_t v [6];
	logic [2:0]     cnt;
	logic           arr;
	sgc_pkg::addr_t ex, ex1, exy, exy1, ex1y1, ea3;

	always_comb begin
		ex    = 34'(x_s3);
		ex1   = 34'(x1_s3);
		exy   = 34'(xy_s3);
		exy1  = 34'(xy1_s3);
		ex1y1 = 34'(x1y1_s3);
		ea3   = 34'(a_s3);
		row   = '0;
		cnt   = 3'd1;
		arr   = 1'b0;
		for (int n = 0; n < 6; n++) v[n] = '0;
		case (dim_s3)
			sgc_pkg::DIM_1: begin
				row  = ea3;
				v[0] = ea3;
				if (op_s3 == sgc_pkg::OP_CELL) begin
					cnt  = 3'd2;
					arr  = 1'b1;
					v[1] = ea3 + 34'd1;
				end
			end
			sgc_pkg::DIM_2: begin
				cnt = 3'd2;
				case (op_s3)
					sgc_pkg::OP_FACE_A: begin
						row  = q0_s3;
						v[0] = q0_s3;
						v[1] = q0_s3 + ex;
					end
					sgc_pkg::OP_FACE_B: begin
						row  = exy1 + q1_s3;
						v[0] = q0_s3;
						v[1] = q0_s3 + 34'd1;
					end
					default: begin
						cnt  = 3'd4;
						arr  = 1'b1;
						row  = q1_s3;
						v[0] = q0_s3;
						v[1] = exy1 + q1_s3;
						v[2] = q0_s3 + 34'd1;
						v[3] = exy1 + q1_s3 + ex1;
					end
				endcase
			end
			default: begin
				cnt = 3'd4;
				case (op_s3)
					sgc_pkg::OP_FACE_A: begin
						row  = tr0_s3;
						v[0] = tp_s3;
						v[1] = tp_s3 + ex;
						v[2] = tp_s3 + ex + exy;
						v[3] = tp_s3 + exy;
					end
					sgc_pkg::OP_FACE_B: begin
						row  = nfa_s3 + tr1_s3;
						v[0] = tp_s3;
						v[1] = tp_s3 + 34'd1;
						v[2] = tp_s3 + 34'd1 + exy;
						v[3] = tp_s3 + exy;
					end
					sgc_pkg::OP_FACE_C: begin
						row  = nfab_s3 + tr2_s3;
						v[0] = tp_s3;
						v[1] = tp_s3 + 34'd1;
						v[2] = tp_s3 + 34'd1 + ex;
						v[3] = tp_s3 + ex;
					end
					default: begin
						cnt  = 3'd6;
						arr  = 1'b1;
						row  = tr2_s3;
						v[0] = tr0_s3;
						v[1] = tr0_s3 + 34'd1;
						v[2] = nfa_s3 + tr1_s3;
						v[3] = nfa_s3 + tr1_s3 + ex1;
						v[4] = nfab_s3 + tr2_s3;
						v[5] = nfab_s3 + tr2_s3 + ex1y1;
					end
				endcase
			end
		endcase
	end

	logic           err_s4, hdr_s4, arr_s4;
	logic [2:0]     cnt_s4;
	sgc_pkg::addr_t row_s4;
	sgc_pkg::val_t [5:0] vals_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s4 <= err_s3;
			hdr_s4 <= hdr_s3;
			arr_s4 <= arr;
			cnt_s4 <= cnt;
			row_s4 <= row;
			for (int n = 0; n < 6; n++) vals_s4[n] <= v[n][31:0];
		end
	end

	// ---------------- stage 5: row offset ---------------------------------
	// Row length is the value count plus the optional count word.
	logic [2:0]    len;
	sgc_pkg::row_t row_s5;

	assign len = cnt_s4 + {2'd0, hdr_s4};

	always_ff @(posedge clk) begin
		if (adv) begin
			row_s5.err  <= err_s4;
			row_s5.arr  <= arr_s4;
			row_s5.hdr  <= hdr_s4;
			row_s5.cnt  <= cnt_s4;
			row_s5.base <= 34'(37'(row_s4) * 37'(len));
			row_s5.vals <= vals_s4;
		end
	end

	// ---------------- word serialiser -------------------------------------
	sgc_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (v_s5),
		.load_ready (load_ready),
		.load_row   (row_s5),
		.rsp        (rsp)
	);
endmodule

>>> src/sgc_chk.sv
`include "assert_macros.svh"

module sgc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_arr,
	input logic [33:0] out_address,
	input logic [31:0] out_value,
	input logic        out_is_count,
	input logic        out_last,
	input logic        out_error
);
	// An error result is a lone, empty word.
	`SGC_ASSERT_NOW(a_err_word, clk, arst_n, out_valid && out_error, out_last && out_address == 34'd0 && out_value == 32'd0 && !out_is_count)
	// A count word always has index words after it.
	`SGC_ASSERT_NOW(a_count_not_last, clk, arst_n, out_valid && out_is_count, !out_last && out_value != 32'd0)
	// Words of one row follow at consecutive addresses without a gap.
	`SGC_ASSERT_NEXT(a_row_contig, clk, arst_n, out_valid && out_ready && !out_last, out_valid && out_address == $past(out_address) + 34'd1 && out_arr == $past(out_arr))
	// A stalled word holds.
	`SGC_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_address) && $stable(out_value) && $stable(out_last))
endmodule

bind structured_grid_connectivity_gen sgc_chk u_sgc_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (rsp.valid),
	.out_ready    (rsp.ready),
	.out_arr      (rsp.target_array),
	.out_address  (rsp.address),
	.out_value    (rsp.value),
	.out_is_count (rsp.is_count),
	.out_last     (rsp.last),
	.out_error    (rsp.error)
);
